>>> hdl/likelihood_field_grid_unit_defines.svh
// Assertion macros for the likelihood field grid unit.
`ifndef LIKELIHOOD_FIELD_GRID_UNIT_DEFINES_SVH
`define LIKELIHOOD_FIELD_GRID_UNIT_DEFINES_SVH
// Implication checked at every clock edge, off while in reset.
`define LFG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define LFG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/lfg_pkg.sv
// Shared types and constants of the likelihood field grid unit.
`default_nettype none
package lfg_pkg;
  localparam int unsigned CFG_W = 32;
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ORG_X  = 3'd2;
  localparam logic [2:0] REG_ORG_Y  = 3'd3;
  localparam logic [2:0] REG_RES    = 3'd4;
  localparam logic signed [7:0] OCC_THRESHOLD = 8'sd50;
  localparam logic [5:0] CELL_MAX = 6'd63;
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int unsigned DIV_N = 33;

  // Item as queued between front and back.
  typedef struct packed {
    logic        is_query;
    logic [7:0]  col;
    logic [7:0]  row;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } cmd_t;
endpackage
`default_nettype wire

>>> hdl/lfg_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module lfg_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hdl/lfg_front.sv
// Front end: accepts items, drops dead loads, forms origin offsets.
`default_nettype none
module lfg_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_op,
  input  wire logic [7:0]          in_cell_col,
  input  wire logic [7:0]          in_cell_row,
  input  wire logic signed [7:0]   in_occupancy,
  input  wire logic signed [31:0]  in_world_x,
  input  wire logic signed [31:0]  in_world_y,
  input  wire logic [8:0]          w_use,
  input  wire logic [8:0]          h_use,
  input  wire logic signed [31:0]  org_x,
  input  wire logic signed [31:0]  org_y,
  output logic                     q_valid,
  output lfg_pkg::cmd_t            q_cmd,
  input  wire logic                q_pop,
  output logic                     busy
);
  import lfg_pkg::*;
  localparam int unsigned QD = 2;
  cmd_t q_r [QD];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic acc, keep, push;
  cmd_t c;

  assign in_stall = (cnt_r == 2'(QD));
  assign acc = in_valid && !in_stall;
  assign keep = (in_op == OP_QUERY) ||
                ({1'b0, in_cell_col} < w_use && {1'b0, in_cell_row} < h_use &&
                 in_occupancy > OCC_THRESHOLD);
  assign push = acc && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rp_r];
  assign busy = q_valid;

  always_comb begin
    c.is_query = in_op;
    c.col = in_cell_col;
    c.row = in_cell_row;
    c.dx = 33'(in_world_x) - 33'(org_x);
    c.dy = 33'(in_world_y) - 33'(org_y);
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
    end
    if (push) q_r[wp_r] <= c;
  end
endmodule
`default_nettype wire

>>> hdl/lfg_back.sv
// Back end: neighborhood updates, serial cell divide, store lookup.
`default_nettype none
module lfg_back #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire lfg_pkg::cmd_t      q_cmd,
  output logic                    q_pop,
  input  wire logic [8:0]         w_use,
  input  wire logic [8:0]         h_use,
  input  wire logic [30:0]        res,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              out_likelihood_quarters,
  output logic                    out_outside_grid,
  output logic                    busy
);
  import lfg_pkg::*;
  localparam int unsigned CB = $clog2(MAX_COLS);
  localparam int unsigned RB = $clog2(MAX_ROWS);
  localparam int unsigned AB = CB + RB;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001, S_IDLE = 8'b0000_0010, S_RD   = 8'b0000_0100,
    S_WR   = 8'b0000_1000, S_DIV  = 8'b0001_0000, S_CHK  = 8'b0010_0000,
    S_QRD  = 8'b0100_0000, S_OUT  = 8'b1000_0000
  } st_t;
  st_t st_r, st_nxt;

  logic [AB-1:0] clr_r, clr_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic signed [3:0] di_r, di_nxt, dj_r, dj_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  logic [32:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [31:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic negx_r, negx_nxt, negy_r, negy_nxt;
  logic [5:0] val_r, val_nxt;
  logic out_r, out_nxt, ov_r, ov_nxt;
  logic pout_r, pout_nxt;
  logic [AB-1:0] addr;
  logic we;
  logic [5:0] wdata, rdata;

  logic signed [9:0] ci, rj;
  logic [1:0] inc;
  logic [6:0] sum;
  logic [32:0] trx, try_;
  logic [33:0] fx, fy;
  logic signed [34:0] ixs, iys;

  lfg_ram #(.WIDTH(6), .DEPTH(1 << AB)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_likelihood_quarters = val_r;
  assign out_outside_grid = out_r;
  assign busy = (st_r != S_IDLE) || ov_r;

  always_comb begin
    ci = 10'(cmd_r.col) + 10'(di_r);
    rj = 10'(cmd_r.row) + 10'(dj_r);
    inc = 2'd1 + 2'(di_r >= -4'sd1 && di_r <= 4'sd1 && dj_r >= -4'sd1 && dj_r <= 4'sd1)
        + 2'(di_r == 4'sd0 && dj_r == 4'sd0);
    sum = 7'(rdata) + 7'(inc);
    // restoring division step on magnitudes
    trx = {rx_r, qx_r[32]} - {2'b0, res};
    try_ = {ry_r, qy_r[32]} - {2'b0, res};
    // floor for negative dividend: -(q + (rem != 0))
    fx = {1'b0, qx_r} + 34'(rx_r != '0);
    fy = {1'b0, qy_r} + 34'(ry_r != '0);
    ixs = negx_r ? -35'(fx) : 35'(qx_r);
    iys = negy_r ? -35'(fy) : 35'(qy_r);

    st_nxt = st_r; clr_nxt = clr_r; cmd_nxt = cmd_r; di_nxt = di_r; dj_nxt = dj_r;
    dcnt_nxt = dcnt_r; qx_nxt = qx_r; qy_nxt = qy_r; rx_nxt = rx_r; ry_nxt = ry_r;
    negx_nxt = negx_r; negy_nxt = negy_r; val_nxt = val_r; out_nxt = out_r;
    pout_nxt = pout_r;
    ov_nxt = ov_r && out_stall;
    we = 1'b0; wdata = '0;
    // in-bounds indexes are never negative, so the casts keep their value
    addr = {CB'(ci), RB'(rj)};

    case (st_r)
      S_CLR: begin
        addr = clr_r; we = 1'b1; wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_cmd;
          di_nxt = -4'sd2; dj_nxt = -4'sd2;
          negx_nxt = q_cmd.dx[32]; negy_nxt = q_cmd.dy[32];
          qx_nxt = q_cmd.dx[32] ? -q_cmd.dx : q_cmd.dx;
          qy_nxt = q_cmd.dy[32] ? -q_cmd.dy : q_cmd.dy;
          rx_nxt = '0; ry_nxt = '0; dcnt_nxt = '0;
          st_nxt = q_cmd.is_query ? S_DIV : S_RD;
        end
      end
      S_RD: begin
        if (ci < 0 || ci >= 10'(w_use) || rj < 0 || rj >= 10'(h_use)) begin
          if (dj_r == 4'sd2) begin
            dj_nxt = -4'sd2;
            if (di_r == 4'sd2) st_nxt = S_IDLE;
            else di_nxt = di_r + 4'sd1;
          end else dj_nxt = dj_r + 4'sd1;
        end else st_nxt = S_WR;
      end
      S_WR: begin
        we = 1'b1;
        wdata = (sum > 7'(CELL_MAX)) ? CELL_MAX : sum[5:0];
        st_nxt = S_RD;
        if (dj_r == 4'sd2) begin
          dj_nxt = -4'sd2;
          if (di_r == 4'sd2) st_nxt = S_IDLE;
          else di_nxt = di_r + 4'sd1;
        end else dj_nxt = dj_r + 4'sd1;
      end
      S_DIV: begin
        qx_nxt = {qx_r[31:0], ~trx[32]};
        rx_nxt = trx[32] ? {rx_r[30:0], qx_r[32]} : trx[31:0];
        qy_nxt = {qy_r[31:0], ~try_[32]};
        ry_nxt = try_[32] ? {ry_r[30:0], qy_r[32]} : try_[31:0];
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'(DIV_N - 1)) st_nxt = S_CHK;
      end
      S_CHK: begin
        if (res != '0 && ixs >= 0 && iys >= 0 &&
            ixs < 35'(w_use) && iys < 35'(h_use)) begin
          cmd_nxt.col = 8'(ixs);
          cmd_nxt.row = 8'(iys);
          di_nxt = '0; dj_nxt = '0;
          pout_nxt = 1'b0;
          st_nxt = S_QRD;
        end else begin
          pout_nxt = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_QRD: begin
        st_nxt = S_OUT;
      end
      S_OUT: begin
        // result registers load only once the previous item has left
        if (!ov_r || !out_stall) begin
          val_nxt = pout_r ? 6'h0 : rdata;
          out_nxt = pout_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
    end
    cmd_r <= cmd_nxt; di_r <= di_nxt; dj_r <= dj_nxt; dcnt_r <= dcnt_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt; rx_r <= rx_nxt; ry_r <= ry_nxt;
    negx_r <= negx_nxt; negy_r <= negy_nxt; val_r <= val_nxt; out_r <= out_nxt;
    pout_r <= pout_nxt;
  end
endmodule
`default_nettype wire

>>> hdl/likelihood_field_grid_unit.sv
// Top level of the likelihood field grid unit.
// Usage:
//   Input channel (in_valid/in_stall): op 0 loads one occupancy cell, op 1
//   queries a world point. Loads give no result; queries give exactly one
//   result on the out channel (out_valid/out_stall), in order.
//   Config: cfg_we/cfg_index/cfg_wdata, written only while idle.
// Sequence (the back end holds one item at a time):
//   Query: pop, 33-step restoring divide on both axes in parallel, range
//   check, one registered RAM read, output register; a point that maps
//   outside skips the RAM read.
//   Load inside the grid and above threshold: pop, then 25 neighbor cells at
//   a read and a write each on the single-port store; an off-grid neighbor
//   gets no write; other loads are dropped at the front.
// Reset: synchronous, active low. After reset the store is cleared one entry
//   per cycle (2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries, 65536 by
//   default); items wait in the two-entry front queue meanwhile, then stall.
// Stall: a held result keeps its payload; the back end finishes the next
//   item and waits, the front queue fills and then stalls the input.
`default_nettype none
module likelihood_field_grid_unit #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_cell_col,
  input  wire logic [7:0]         in_cell_row,
  input  wire logic signed [7:0]  in_occupancy,
  input  wire logic signed [31:0] in_world_x,
  input  wire logic signed [31:0] in_world_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              out_likelihood_quarters,
  output logic                    out_outside_grid
);
  import lfg_pkg::*;
  `include "likelihood_field_grid_unit_defines.svh"

  logic [8:0] width_r, height_r, w_use, h_use;
  logic signed [31:0] org_x_r, org_y_r;
  logic [30:0] res_r;
  logic q_valid, q_pop, fbusy, bbusy;
  cmd_t q_cmd;

  // Sizes beyond the store clamp to it.
  assign w_use = (32'(width_r) > MAX_COLS) ? 9'(MAX_COLS) : width_r;
  assign h_use = (32'(height_r) > MAX_ROWS) ? 9'(MAX_ROWS) : height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256; height_r <= 9'd256;
      org_x_r <= '0; org_y_r <= '0; res_r <= 31'd3277;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r <= cfg_wdata[8:0];
        REG_HEIGHT: height_r <= cfg_wdata[8:0];
        REG_ORG_X:  org_x_r <= cfg_wdata;
        REG_ORG_Y:  org_y_r <= cfg_wdata;
        REG_RES:    res_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  lfg_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_cell_col, .in_cell_row,
    .in_occupancy, .in_world_x, .in_world_y, .w_use, .h_use,
    .org_x(org_x_r), .org_y(org_y_r), .q_valid, .q_cmd, .q_pop, .busy(fbusy));

  lfg_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .w_use, .h_use, .res(res_r),
    .out_valid, .out_stall, .out_likelihood_quarters, .out_outside_grid,
    .busy(bbusy));

  `LFG_ASSERT_IMPL(a_out_range, clk, rst_n, out_valid && !out_outside_grid,
    out_likelihood_quarters <= CELL_MAX, "result out of range")
  `LFG_ASSERT_IMPL(a_outside_zero, clk, rst_n, out_valid && out_outside_grid,
    out_likelihood_quarters == 6'd0, "outside result not zero")
  `LFG_ASSERT_NEXT(a_pop_busy, clk, rst_n, q_pop, bbusy, "back end idle after pop")
  `LFG_ASSERT_IMPL(a_pop_valid, clk, rst_n, q_pop, q_valid && fbusy,
    "pop from empty queue")
endmodule
`default_nettype wire

>>> bench/lfg_checker.sv
// Checker for the likelihood field grid unit: tracks the grid, predicts query answers, compares.
`default_nettype none
module lfg_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_cell_col,
  input  wire logic [7:0]         in_cell_row,
  input  wire logic signed [7:0]  in_occupancy,
  input  wire logic signed [31:0] in_world_x,
  input  wire logic signed [31:0] in_world_y,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [5:0]         out_likelihood_quarters,
  input  wire logic               out_outside_grid,
  output int                      fail_count,
  output int                      answers_due,
  output int                      answers_seen
);
  import lfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0] quarters;
    logic       outside;
  } answer_t;

  localparam int ANS_DEPTH = 1024;

  logic [5:0]  grid_copy [0:65535];
  logic [8:0]  width_reg, height_reg;
  logic signed [31:0] org_x, org_y;
  logic [30:0] res_reg;
  answer_t     pending_answers [0:ANS_DEPTH-1];
  int          ans_wr = 0;
  int          ans_rd = 0;

  initial begin
    fail_count = 0;
    answers_seen = 0;
    foreach (grid_copy[k]) grid_copy[k] = '0;
  end

  assign answers_due = ans_wr - ans_rd;

  function automatic longint floor_cell(longint d, longint r);
    if (d >= 0) return d / r;
    return -((-d + r - 1) / r);
  endfunction

  task automatic bump_ring(int c, int rw, int rad, int w, int h);
    int i, j;
    for (i = c - rad; i <= c + rad; i++)
      for (j = rw - rad; j <= rw + rad; j++)
        if (i >= 0 && i < w && j >= 0 && j < h && grid_copy[i*256+j] != CELL_MAX)
          grid_copy[i*256+j] = grid_copy[i*256+j] + 6'd1;
  endtask

  task automatic take_item();
    int w, h;
    longint ix, iy;
    answer_t a;
    w = (width_reg > 256) ? 256 : width_reg;
    h = (height_reg > 256) ? 256 : height_reg;
    if (in_op == OP_LOAD) begin
      if (in_cell_col < w && in_cell_row < h && in_occupancy > OCC_THRESHOLD) begin
        bump_ring(in_cell_col, in_cell_row, 2, w, h);
        bump_ring(in_cell_col, in_cell_row, 1, w, h);
        bump_ring(in_cell_col, in_cell_row, 0, w, h);
      end
    end else begin
      a.quarters = '0;
      a.outside = 1'b1;
      if (res_reg != 0) begin
        ix = floor_cell(longint'(in_world_x) - longint'(org_x), longint'(res_reg));
        iy = floor_cell(longint'(in_world_y) - longint'(org_y), longint'(res_reg));
        if (ix >= 0 && iy >= 0 && ix < w && iy < h) begin
          a.quarters = grid_copy[ix*256+iy];
          a.outside = 1'b0;
        end
      end
      pending_answers[ans_wr % ANS_DEPTH] = a;
      ans_wr++;
    end
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (!rst_n) begin
      width_reg <= 9'd256;
      height_reg <= 9'd256;
      org_x <= '0;
      org_y <= '0;
      res_reg <= 31'd3277;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg <= cfg_wdata[8:0];
          REG_HEIGHT: height_reg <= cfg_wdata[8:0];
          REG_ORG_X:  org_x <= cfg_wdata;
          REG_ORG_Y:  org_y <= cfg_wdata;
          REG_RES:    res_reg <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_item();
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (ans_wr == ans_rd) begin
          $display("%0t: unexpected result q=%0d out=%0b", $time,
                   out_likelihood_quarters, out_outside_grid);
          fail_count++;
        end else begin
          e = pending_answers[ans_rd % ANS_DEPTH];
          ans_rd++;
          if (e.quarters !== out_likelihood_quarters) begin
            $display("%0t: likelihood exp %0d got %0d", $time, e.quarters,
                     out_likelihood_quarters);
            fail_count++;
          end
          if (e.outside !== out_outside_grid) begin
            $display("%0t: outside exp %0b got %0b", $time, e.outside,
                     out_outside_grid);
            fail_count++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> bench/tb_likelihood_field_grid_unit.sv
// Testbench top for the likelihood field grid unit: stimulus, idling, verdict.
`default_nettype none
module tb_likelihood_field_grid_unit;
  import lfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic [7:0] in_cell_col = '0, in_cell_row = '0;
  logic signed [7:0] in_occupancy = '0;
  logic signed [31:0] in_world_x = '0, in_world_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_likelihood_quarters;
  logic out_outside_grid;
  int fail_count, answers_due, answers_seen;

  // Idle percentages per side; hold_off starts one long receiver stall.
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  // Current grid size, used to aim loads and queries at and around the grid.
  int cur_w = 256, cur_h = 256, cur_res = 3277;
  int cur_ox = 0, cur_oy = 0;

  always #5 clk = ~clk;

  likelihood_field_grid_unit dut (.*);

  lfg_checker checker_i (.*);

  // Receiver: random stall, or a held stall counted by hold_cnt once hold_off is up.
  always @(posedge clk) begin
    if (hold_off && hold_cnt < 400) hold_cnt <= hold_cnt + 1;
    out_stall <= (hold_off && hold_cnt < 400) || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: covers the store clear after reset plus stalled stretches.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("tb_likelihood_field_grid_unit: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for all answers, then let the loads still in flight finish
  // (one in the back end and two queued).
  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Offer one item and hold it until accepted; valid drops on the next idle.
  task automatic offer(logic op, logic [7:0] c, logic [7:0] r, logic [7:0] occ,
                       logic [31:0] wx, logic [31:0] wy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_cell_col <= c;
    in_cell_row <= r;
    in_occupancy <= occ;
    in_world_x <= wx;
    in_world_y <= wy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic set_grid(int w, int h, int ox, int oy, int res);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_RES, res);
    cur_w = (w > 256) ? 256 : w;
    cur_h = (h > 256) ? 256 : h;
    cur_ox = ox;
    cur_oy = oy;
    cur_res = res;
  endtask

  // Point at the given cell with random sub-cell offset (small res only).
  task automatic query_cell(int c, int r);
    longint wx, wy;
    wx = longint'(cur_ox) + longint'(c) * cur_res + $urandom_range(cur_res - 1);
    wy = longint'(cur_oy) + longint'(r) * cur_res + $urandom_range(cur_res - 1);
    offer(OP_QUERY, $urandom, $urandom, $urandom, wx[31:0], wy[31:0]);
  endtask

  // Mostly occupied loads inside the grid, queries around them, some noise.
  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 40)
      offer(OP_LOAD, $urandom_range(cur_w + 2), $urandom_range(cur_h + 2),
            ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(100, 51)),
            $urandom, $urandom);
    else if (k < 90)
      query_cell(int'($urandom_range(cur_w + 1)) - 1, int'($urandom_range(cur_h + 1)) - 1);
    else
      offer(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int i, ph;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset config, corner loads, threshold, extremes.
    offer(OP_LOAD, 8'd0, 8'd0, 8'sd100, 0, 0);
    offer(OP_LOAD, 8'd255, 8'd255, 8'sd51, 0, 0);
    offer(OP_LOAD, 8'd10, 8'd10, 8'sd50, 0, 0);
    offer(OP_LOAD, 8'd10, 8'd10, -8'sd1, 0, 0);
    offer(OP_LOAD, 8'd10, 8'd10, -8'sd128, 0, 0);
    offer(OP_LOAD, 8'd10, 8'd10, 8'sd127, 0, 0);
    query_cell(0, 0);
    query_cell(1, 1);
    query_cell(255, 255);
    query_cell(10, 10);
    offer(OP_QUERY, 0, 0, 0, 32'h7fffffff, 32'h80000000);
    offer(OP_QUERY, 0, 0, 0, 32'hffffffff, 32'h0);
    set_grid(8, 6, -32'sd65536, 32'sd1000, 16);
    for (i = 0; i < 10; i++) offer(OP_LOAD, 8'd3, 8'd2, 8'sd90, 0, 0);
    offer(OP_LOAD, 8'd8, 8'd1, 8'sd90, 0, 0);
    query_cell(3, 2);
    query_cell(7, 5);
    query_cell(8, 0);
    set_grid(0, 300, 32'h80000000, 32'h7fffffff, 1);
    offer(OP_LOAD, 8'd0, 8'd0, 8'sd90, 0, 0);
    offer(OP_QUERY, 0, 0, 0, 32'h80000000, 32'h7fffffff);
    set_grid(300, 5, 0, 0, 0);
    offer(OP_QUERY, 0, 0, 0, 0, 0);
    set_grid(200, 200, 32'h7fffffff, 0, 32'h7fffffff);
    offer(OP_QUERY, 0, 0, 0, 32'h80000000, 32'h7fffffff);

    // Random phases: receiver-heavy idling, sender-heavy, then none.
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 26; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      set_grid($urandom_range(5, 40), $urandom_range(5, 40),
               $urandom, $urandom, $urandom_range(1, 4000));
      for (i = 0; i < 270; i++) begin
        // Long receiver hold-off while items keep coming, so the input backs up.
        if (i == 100) hold_off = 1'b1;
        if (i == 200) drain();
        random_item();
      end
    end

    drain();
    $display("Sent %0d items, checked %0d answers across several grid sizes,", items_sent,
             answers_seen);
    $display("origins, resolutions and idling mixes.");
    if (fail_count == 0 && answers_due == 0) begin
      $display("tb_likelihood_field_grid_unit: clean");
    end else begin
      $display("tb_likelihood_field_grid_unit: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
